FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the supervisor RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is applied.
`define NMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form, antecedent then consequent in the following cycle.
`define NMS_ASSERT_NEXT(label, ante, cons, msg) \
  `NMS_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/nms_pkg.sv
// Shared types and constants for the navigator mode supervisor.
// No dependencies; every RTL module refers to it by scoped names.
`default_nettype none

package nms_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int NUM_RANGES   = 5;
  localparam int NUM_LANES    = (SENSOR_COUNT < NUM_RANGES) ? SENSOR_COUNT : NUM_RANGES;

  localparam int RANGE_W  = 12;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COUNT_W-1:0] HYST_LIMIT_RST = 16'd10;
  localparam logic [COUNT_W-1:0] STEP_LIMIT_RST = 16'd400;

  typedef enum logic [1:0] {
    MODE_CLOSE   = 2'd0,
    MODE_LONG    = 2'd1,
    MODE_FEATURE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYST_LIMIT   = 3'd0,
    CFG_STEP_LIMIT   = 3'd1,
    CFG_COLL_DIST    = 3'd2,
    CFG_CLOSE_EN     = 3'd3,
    CFG_LONG_EN      = 3'd4,
    CFG_FEATURE_EN   = 3'd5
  } cfg_idx_t;

  typedef logic [RANGE_W-1:0] range_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hyst_limit;
    logic [COUNT_W-1:0] step_limit;
    range_t             coll_dist;
    logic               close_en;
    logic               long_en;
    logic               feature_en;
  } cfg_t;

  typedef struct packed {
    logic exec_ready;
    logic feature_active;
    logic close_cmd_ready;
    logic long_cmd_ready;
    logic exec_busy;
    logic long_mission_done;
  } tick_t;

  typedef struct packed {
    mode_t              active_mode;
    logic               forward_cmd;
    logic               ack_navigator;
    logic               route_obsolete;
    logic               stop_all;
    logic               mission_over;
    logic               hysteresis_met;
    logic               collision;
    logic [COUNT_W-1:0] steps_done;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nms_lane.sv
// One collision lane: checks a single range reading against the threshold.
// Depends on nms_pkg.
`default_nettype none

module nms_lane (
  input  wire nms_pkg::range_t reading,
  input  wire nms_pkg::range_t coll_dist,
  output logic                 hit
);

  // zero means no echo, never a collision
  assign hit = (reading != '0) && (reading < coll_dist);

endmodule

`default_nettype wire

FILE: hw/rtl/nms_merge.sv
// Collision lanes side by side plus the OR merge of their hits.
// Depends on nms_pkg and nms_lane.
`default_nettype none

module nms_merge (
  input  wire nms_pkg::range_t ranges [nms_pkg::NUM_RANGES],
  input  wire nms_pkg::range_t coll_dist,
  output logic                 collision
);

  logic [nms_pkg::NUM_LANES-1:0] lane_hit;

  for (genvar g = 0; g < nms_pkg::NUM_LANES; g++) begin : g_lane
    nms_lane u_lane (
      .reading   (ranges[g]),
      .coll_dist (coll_dist),
      .hit       (lane_hit[g])
    );
  end

  assign collision = |lane_hit;

endmodule

`default_nettype wire

FILE: hw/rtl/nms_ctrl.sv
// Mode selection, executive handshake and step counters of the supervisor.
// Depends on nms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nms_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   tick_acc,
  input  wire nms_pkg::tick_t   tick,
  input  wire                   collision,
  input  wire nms_pkg::cfg_t    cfg,
  output nms_pkg::result_t      result
);

  nms_pkg::mode_t               mode_r, mode_nxt;
  logic                         awaiting_r, awaiting_nxt;
  logic [nms_pkg::COUNT_W-1:0]  close_cnt_r, close_cnt_nxt;
  logic [nms_pkg::COUNT_W-1:0]  step_r, step_nxt;
  logic                         mission_r, mission_nxt;

  logic hyst, stop, go, close_eff, fflag, cmd_ready;
  logic fwd, ack, obsolete;
  nms_pkg::mode_t mode_sel;
  logic [nms_pkg::COUNT_W-1:0] close_cnt_sel;

  always_comb begin
    hyst      = close_cnt_r > cfg.hyst_limit;
    stop      = step_r >= cfg.step_limit;
    go        = tick_acc && !stop && !mission_r && tick.exec_ready;
    close_eff = cfg.close_en || !cfg.long_en;
    fflag     = cfg.feature_en && tick.feature_active;

    mode_sel      = mode_r;
    close_cnt_sel = close_cnt_r;
    obsolete      = 1'b0;
    unique case (mode_r)
      nms_pkg::MODE_CLOSE: begin
        if (cfg.long_en && hyst && !collision && !fflag)
          mode_sel = nms_pkg::MODE_LONG;
        else if (cfg.feature_en && hyst && !collision && fflag)
          mode_sel = nms_pkg::MODE_FEATURE;
        if (collision)
          close_cnt_sel = '0;
      end
      nms_pkg::MODE_LONG: begin
        if ((close_eff && collision) || !cfg.long_en) begin
          mode_sel      = nms_pkg::MODE_CLOSE;
          close_cnt_sel = '0;
          obsolete      = 1'b1;
        end
      end
      default: ;  // feature mode has no way out
    endcase

    // feature navigator never has a command ready
    unique case (mode_sel)
      nms_pkg::MODE_CLOSE: cmd_ready = tick.close_cmd_ready;
      nms_pkg::MODE_LONG:  cmd_ready = tick.long_cmd_ready;
      default:             cmd_ready = 1'b0;
    endcase

    fwd = go && !awaiting_r && cmd_ready;
    ack = go && awaiting_r && !tick.exec_busy;

    mode_nxt      = mode_r;
    awaiting_nxt  = awaiting_r;
    close_cnt_nxt = close_cnt_r;
    step_nxt      = step_r;
    mission_nxt   = mission_r;
    if (go) begin
      mode_nxt      = mode_sel;
      close_cnt_nxt = close_cnt_sel;
      if (fwd)
        awaiting_nxt = 1'b1;
      if (ack) begin
        awaiting_nxt = 1'b0;
        step_nxt     = step_r + 16'd1;
        // saturating close-range count
        if (mode_sel == nms_pkg::MODE_CLOSE && close_cnt_sel != '1)
          close_cnt_nxt = close_cnt_sel + 16'd1;
      end
      if (tick.long_mission_done)
        mission_nxt = 1'b1;
    end
  end

  always_comb begin
    result.active_mode    = mode_nxt;
    result.forward_cmd    = fwd;
    result.ack_navigator  = ack;
    result.route_obsolete = go && obsolete;
    result.stop_all       = stop;
    result.mission_over   = mission_nxt;
    result.hysteresis_met = hyst;
    result.collision      = collision;
    result.steps_done     = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= nms_pkg::MODE_CLOSE;
      awaiting_r  <= 1'b0;
      close_cnt_r <= '0;
      step_r      <= '0;
      mission_r   <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      awaiting_r  <= awaiting_nxt;
      close_cnt_r <= close_cnt_nxt;
      step_r      <= step_nxt;
      mission_r   <= mission_nxt;
    end
  end

  `NMS_ASSERT_NEXT(a_fwd_sets_wait, fwd, awaiting_r, "forward did not open wait phase")
  `NMS_ASSERT_NEXT(a_step_only_on_ack, !ack, $stable(step_r), "step count moved without ack")
  `NMS_ASSERT_NEXT(a_feature_sticky, mode_r == nms_pkg::MODE_FEATURE, $stable(mode_r), "left feature")
  `NMS_ASSERT_NEXT(a_mission_sticky, mission_r, mission_r, "mission latch cleared")

endmodule

`default_nettype wire

FILE: hw/rtl/navigator_mode_supervisor_top.sv
// Top level of the navigator mode supervisor: stream ports, config registers, output stage.
// Depends on nms_pkg, nms_merge (with nms_lane) and nms_ctrl.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata  : tick flags and five range readings
//  out_    | out | out_tvalid/tready  | out_tdata : mode, handshake flags, step count
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data : register writes
//
// One tick per clock unless out_tready stalls: collision lanes, mode select and
// counters settle into the output register at accept; results show the next cycle.
// in_tready stays high while the output register is empty or being drained.
// Synchronous active-low reset; cfg_ready is always high.
`default_nettype none

module navigator_mode_supervisor_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [0] exec_ready, [12:1] range0, [24:13] range1, [36:25] range2, [48:37] range3,
  // [60:49] range4, [61] feature_active, [62] close_cmd_ready, [63] long_cmd_ready,
  // [64] exec_busy, [65] long_mission_done, [71:66] zero
  input  wire  [nms_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [1:0] active_mode, [2] forward_cmd, [3] ack_navigator, [4] route_obsolete,
  // [5] stop_all, [6] mission_over, [7] hysteresis_met, [8] collision,
  // [24:9] steps_done, [31:25] zero
  output logic [nms_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [nms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [nms_pkg::CFG_DATA_W-1:0]       cfg_data
);

  nms_pkg::cfg_t    cfg_r;
  nms_pkg::tick_t   tick;
  nms_pkg::range_t  ranges [nms_pkg::NUM_RANGES];
  nms_pkg::result_t result;
  logic             collision;
  logic             in_acc;
  logic             out_valid_r;
  logic [nms_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hyst_limit <= nms_pkg::HYST_LIMIT_RST;
      cfg_r.step_limit <= nms_pkg::STEP_LIMIT_RST;
      cfg_r.coll_dist  <= '0;
      cfg_r.close_en   <= 1'b1;
      cfg_r.long_en    <= 1'b1;
      cfg_r.feature_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (nms_pkg::cfg_idx_t'(cfg_index))
        nms_pkg::CFG_HYST_LIMIT: cfg_r.hyst_limit <= cfg_data;
        nms_pkg::CFG_STEP_LIMIT: cfg_r.step_limit <= cfg_data;
        nms_pkg::CFG_COLL_DIST:  cfg_r.coll_dist  <= cfg_data[nms_pkg::RANGE_W-1:0];
        nms_pkg::CFG_CLOSE_EN:   cfg_r.close_en   <= cfg_data[0];
        nms_pkg::CFG_LONG_EN:    cfg_r.long_en    <= cfg_data[0];
        nms_pkg::CFG_FEATURE_EN: cfg_r.feature_en <= cfg_data[0];
        default: ;  // unused indices are dropped
      endcase
    end
  end

  always_comb begin
    tick.exec_ready        = in_tdata[0];
    tick.feature_active    = in_tdata[61];
    tick.close_cmd_ready   = in_tdata[62];
    tick.long_cmd_ready    = in_tdata[63];
    tick.exec_busy         = in_tdata[64];
    tick.long_mission_done = in_tdata[65];
  end

  for (genvar g = 0; g < nms_pkg::NUM_RANGES; g++) begin : g_range
    assign ranges[g] = in_tdata[1 + g*nms_pkg::RANGE_W +: nms_pkg::RANGE_W];
  end

  nms_merge u_merge (
    .ranges    (ranges),
    .coll_dist (cfg_r.coll_dist),
    .collision (collision)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  nms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_acc  (in_acc),
    .tick      (tick),
    .collision (collision),
    .cfg       (cfg_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {7'd0, result.steps_done, result.collision, result.hysteresis_met,
                      result.mission_over, result.stop_all, result.route_obsolete,
                      result.ack_navigator, result.forward_cmd, result.active_mode};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
